>>> sv/iolh_pkg.sv
// Package holding the types, constants and codes shared by the latency histogram block.
package iolh_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int BIN_COUNT_DEF   = 32;
    localparam logic [9:0] NS_PER_US   = 10'd1000;
    localparam logic [7:0] READ_CHAR   = 8'd82;
    localparam int         SECTOR_SHIFT = 9;

    localparam logic [1:0] MODE_ISSUE    = 2'd0;
    localparam logic [1:0] MODE_COMPLETE = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] device_id;
        logic [63:0] sector_number;
        logic [63:0] time_ns;
        logic [31:0] sector_count;
        logic [7:0]  op_code_char;
        logic [6:0]  stat_index;
    } iolh_in_t;

    typedef struct packed {
        logic        matched;
        logic [54:0] latency_micros;
        logic [4:0]  bin_index;
        logic        counted_as_read;
        logic        table_full_drop;
        logic [63:0] stat_value;
    } iolh_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DIVIDE,
        ST_LOG,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_STAT,
        ST_OUT
    } iolh_state_t;

endpackage

>>> sv/iolh_div.sv
// Divider by 1000 that multiplies by a fixed reciprocal through one shared 32 by 32 multiplier.
module iolh_div
    import iolh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    output logic        done,
    output logic [63:0] quotient
);
    localparam logic [61:0] DIV_RECIP = 62'd2361183241434822607;
    localparam int          DIV_SHIFT = 68;

    logic [63:0]  x_reg, x_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [127:0] addend;

    // The dividend is divided by eight first, and the rest by 125 is a product with a
    // rounded-up reciprocal that is built from four 32-bit partial products.
    assign mul_a  = step_reg[1] ? {3'd0, x_reg[63:35]} : x_reg[34:3];
    assign mul_b  = step_reg[0] ? {2'd0, DIV_RECIP[61:32]} : DIV_RECIP[31:0];
    assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
    assign addend = {64'd0, prod} << {step_reg[1] & step_reg[0], step_reg[1] ^ step_reg[0],
                                      5'd0};

    always_comb begin
        x_next    = x_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = dividend;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next  = acc_reg + addend;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = {4'd0, acc_reg[127:DIV_SHIFT]};

    a_quot_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (x_reg - quotient * 64'(NS_PER_US)) < 64'(NS_PER_US))
        else $error("divider quotient wrong");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");
endmodule

>>> sv/io_latency_log2_histogram_top.sv
// Top level of the block I/O latency log2 histogram.
// Input items arrive on the s_ channel (s_valid, s_ready, s_data) and one result per item
// leaves on the m_ channel (m_valid, m_ready, m_data); a transfer happens when valid and
// ready are both high.
// An issue or completion searches the key table one entry per cycle through a single
// memory read port. A completion that hits then goes through the divider by 1000, a
// log2 search for the bin and a bin update that reads the bin and writes it back. A
// statistic read and an unused mode skip the search.
// The block takes one item at a time: s_ready is high only while it is idle.
// After reset a pass clears all 2*BIN_COUNT histogram bins, during which no item is taken;
// the key table's valid bits and the totals clear at once.
// A result waits in an output register until the receiver takes it. The next item is
// accepted and worked on meanwhile, and its result holds the block until that register
// is free.
module io_latency_log2_histogram_top
    import iolh_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int BIN_COUNT   = BIN_COUNT_DEF
)(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  iolh_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output iolh_out_t m_data
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW = $clog2(BIN_COUNT);
    localparam int BINMAX = BIN_COUNT - 1;

    logic [31:0] dev_mem  [TABLE_DEPTH];
    logic [63:0] sec_mem  [TABLE_DEPTH];
    logic [63:0] time_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0] bin_mem [2*BIN_COUNT];

    iolh_state_t state_reg, state_next;
    iolh_in_t    item_reg, item_next;
    iolh_out_t   res_reg, res_next;
    iolh_out_t   out_reg, out_next;
    logic        m_valid_reg, m_valid_next;
    logic [AW:0] addr_reg, addr_next;
    logic [AW-1:0] hit_reg, hit_next, free_reg, free_next;
    logic        hit_found_reg, hit_found_next, free_found_reg, free_found_next;
    logic [31:0] rd_dev;
    logic [63:0] rd_sec, rd_time;
    logic [63:0] lat_reg, lat_next;
    logic [BW-1:0] bin_reg, bin_next;
    logic [6:0]  lcnt_reg, lcnt_next;
    logic [BW:0] baddr;
    logic [31:0] bin_rd;
    logic        bin_we;
    logic [31:0] bin_wd;
    logic [63:0] rdone_reg, rdone_next, wdone_reg, wdone_next;
    logic [63:0] rbytes_reg, rbytes_next, wbytes_reg, wbytes_next;
    logic        tbl_we;
    logic [AW-1:0] tbl_wa;
    logic        div_start, div_done;
    logic [63:0] div_q;
    logic [63:0] div_q_hold;
    logic        is_rd;
    logic [63:0] bytes;

    iolh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (item_reg.time_ns - rd_time),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        rd_dev  <= dev_mem[addr_reg[AW-1:0]];
        rd_sec  <= sec_mem[addr_reg[AW-1:0]];
        rd_time <= time_mem[(state_reg == ST_SCAN_WAIT) ? hit_reg : addr_reg[AW-1:0]];
        if (tbl_we) begin
            dev_mem[tbl_wa]  <= item_reg.device_id;
            sec_mem[tbl_wa]  <= item_reg.sector_number;
            time_mem[tbl_wa] <= item_reg.time_ns;
        end
        bin_rd <= bin_mem[baddr];
        if (bin_we) begin
            bin_mem[baddr] <= bin_wd;
        end
    end

    assign is_rd = (item_reg.op_code_char == READ_CHAR);
    assign bytes = {23'd0, item_reg.sector_count, {SECTOR_SHIFT{1'b0}}};

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        addr_next       = addr_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        lat_next        = lat_reg;
        bin_next        = bin_reg;
        lcnt_next       = lcnt_reg;
        rdone_next      = rdone_reg;
        wdone_next      = wdone_reg;
        rbytes_next     = rbytes_reg;
        wbytes_next     = wbytes_reg;
        tbl_we          = 1'b0;
        tbl_wa          = hit_reg;
        div_start       = 1'b0;
        bin_we          = 1'b0;
        bin_wd          = bin_rd + 32'd1;
        baddr           = is_rd ? (BW+1)'(bin_reg)
                                : (BW+1)'(bin_reg) + (BW+1)'(BIN_COUNT);
        s_ready         = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                baddr     = addr_reg[BW:0];
                bin_we    = 1'b1;
                bin_wd    = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg[BW:0] == (BW+1)'(2*BIN_COUNT-1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next       = s_data;
                    res_next        = '0;
                    addr_next       = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    if (s_data.mode == MODE_ISSUE || s_data.mode == MODE_COMPLETE) begin
                        state_next = ST_SCAN;
                    end else if (s_data.mode == MODE_READ) begin
                        state_next = ST_STAT;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (addr_reg != '0) begin
                    if (valid_reg[addr_reg[AW-1:0] - 1'b1] && !hit_found_reg &&
                        rd_dev == item_reg.device_id && rd_sec == item_reg.sector_number) begin
                        hit_found_next = 1'b1;
                        hit_next       = addr_reg[AW-1:0] - 1'b1;
                    end
                    if (!valid_reg[addr_reg[AW-1:0] - 1'b1] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_next       = addr_reg[AW-1:0] - 1'b1;
                    end
                end
                if (addr_reg == (AW+1)'(TABLE_DEPTH)) begin
                    state_next = ST_SCAN_WAIT;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_SCAN_WAIT: begin
                if (item_reg.mode == MODE_ISSUE) begin
                    if (hit_found_reg || free_found_reg) begin
                        tbl_we = 1'b1;
                        tbl_wa = hit_found_reg ? hit_reg : free_reg;
                        valid_next[tbl_wa] = 1'b1;
                    end else begin
                        res_next.table_full_drop = 1'b1;
                    end
                    state_next = ST_OUT;
                end else if (hit_found_reg) begin
                    valid_next[hit_reg] = 1'b0;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIVIDE: begin
                div_start = (lcnt_reg == 7'd0);
                lcnt_next = 7'd1;
                if (div_done) begin
                    lat_next  = div_q;
                    bin_next  = '0;
                    lcnt_next = '0;
                    state_next = ST_LOG;
                end
            end
            ST_LOG: begin
                if (lat_reg > 64'd1 && bin_reg != BW'(BINMAX)) begin
                    lat_next = lat_reg >> 1;
                    bin_next = bin_reg + 1'b1;
                end else begin
                    state_next = ST_BIN_RD;
                end
            end
            ST_BIN_RD: begin
                state_next = ST_BIN_WR;
            end
            ST_BIN_WR: begin
                bin_we = 1'b1;
                res_next.matched         = 1'b1;
                res_next.latency_micros  = div_q_hold[54:0];
                res_next.bin_index       = 5'(bin_reg);
                res_next.counted_as_read = is_rd;
                if (is_rd) begin
                    rdone_next  = rdone_reg + 64'd1;
                    rbytes_next = rbytes_reg + bytes;
                end else begin
                    wdone_next  = wdone_reg + 64'd1;
                    wbytes_next = wbytes_reg + bytes;
                end
                state_next = ST_OUT;
            end
            ST_STAT: begin
                baddr = item_reg.stat_index[BW:0];
                if (lcnt_reg == 7'd0) begin
                    lcnt_next = 7'd1;
                end else begin
                    lcnt_next = '0;
                    if (item_reg.stat_index < 7'(2*BIN_COUNT)) begin
                        res_next.stat_value = {32'd0, bin_rd};
                    end else if (item_reg.stat_index == 7'(2*BIN_COUNT)) begin
                        res_next.stat_value = rdone_reg;
                    end else if (item_reg.stat_index == 7'(2*BIN_COUNT+1)) begin
                        res_next.stat_value = wdone_reg;
                    end else if (item_reg.stat_index == 7'(2*BIN_COUNT+2)) begin
                        res_next.stat_value = rbytes_reg;
                    end else if (item_reg.stat_index == 7'(2*BIN_COUNT+3)) begin
                        res_next.stat_value = wbytes_reg;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (div_done) begin
            div_q_hold <= div_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            addr_reg    <= '0;
            lcnt_reg    <= '0;
            rdone_reg   <= '0;
            wdone_reg   <= '0;
            rbytes_reg  <= '0;
            wbytes_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
            addr_reg    <= addr_next;
            lcnt_reg    <= lcnt_next;
            rdone_reg   <= rdone_next;
            wdone_reg   <= wdone_next;
            rbytes_reg  <= rbytes_next;
            wbytes_reg  <= wbytes_next;
        end
        item_reg       <= item_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
        hit_reg        <= hit_next;
        free_reg       <= free_next;
        hit_found_reg  <= hit_found_next;
        free_found_reg <= free_found_next;
        lat_reg        <= lat_next;
        bin_reg        <= bin_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_drop_only_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full_drop |-> !m_data.matched)
        else $error("drop and match together");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_data))
        else $error("result changed while waiting");
endmodule

>>> test/tb_io_latency_log2_histogram_top.sv
// Testbench for the block I/O latency histogram: random and directed items checked against a predictor.
module tb_io_latency_log2_histogram_top;
    import iolh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int BINS = BIN_COUNT_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    class latency_scoreboard;
        bit          slot_used[DEPTH];
        logic [31:0] slot_dev[DEPTH];
        logic [63:0] slot_sec[DEPTH];
        logic [63:0] slot_start[DEPTH];
        logic [31:0] rd_bins[BINS];
        logic [31:0] wr_bins[BINS];
        logic [63:0] rd_count, wr_count, rd_bytes, wr_bytes;
        iolh_out_t   pending[$];
        int          mismatches;
        int          hits, drops, checked;

        function void note_item(iolh_in_t it);
            iolh_out_t r;
            int k;
            logic [63:0] us, v;
            int b;
            r = '0;
            k = -1;
            if (it.mode == MODE_ISSUE || it.mode == MODE_COMPLETE) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (k < 0 && slot_used[i] && slot_dev[i] == it.device_id
                        && slot_sec[i] == it.sector_number) k = i;
                end
            end
            if (it.mode == MODE_ISSUE) begin
                if (k < 0) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (k < 0 && !slot_used[i]) k = i;
                    end
                end
                if (k < 0) begin
                    r.table_full_drop = 1'b1;
                    drops++;
                end else begin
                    slot_used[k] = 1'b1;
                    slot_dev[k] = it.device_id;
                    slot_sec[k] = it.sector_number;
                    slot_start[k] = it.time_ns;
                end
            end else if (it.mode == MODE_COMPLETE && k >= 0) begin
                us = (it.time_ns - slot_start[k]) / 64'd1000;
                b = 0;
                v = us;
                while (v > 1) begin
                    v = v >> 1;
                    b++;
                end
                if (b > BINS - 1) b = BINS - 1;
                v = {32'd0, it.sector_count} << SECTOR_SHIFT;
                if (it.op_code_char == READ_CHAR) begin
                    rd_bins[b]++;
                    rd_count++;
                    rd_bytes += v;
                end else begin
                    wr_bins[b]++;
                    wr_count++;
                    wr_bytes += v;
                end
                slot_used[k] = 1'b0;
                r.matched = 1'b1;
                r.latency_micros = us[54:0];
                r.bin_index = b[4:0];
                r.counted_as_read = (it.op_code_char == READ_CHAR);
                hits++;
            end else if (it.mode == MODE_READ) begin
                if (it.stat_index < BINS) r.stat_value = rd_bins[it.stat_index];
                else if (it.stat_index < 2 * BINS)
                    r.stat_value = wr_bins[it.stat_index - BINS];
                else if (it.stat_index == 2 * BINS) r.stat_value = rd_count;
                else if (it.stat_index == 2 * BINS + 1) r.stat_value = wr_count;
                else if (it.stat_index == 2 * BINS + 2) r.stat_value = rd_bytes;
                else if (it.stat_index == 2 * BINS + 3) r.stat_value = wr_bytes;
            end
            pending.push_back(r);
        endfunction

        function void check_result(iolh_out_t got);
            iolh_out_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.matched !== want.matched || got.latency_micros !== want.latency_micros
                || got.bin_index !== want.bin_index
                || got.counted_as_read !== want.counted_as_read
                || got.table_full_drop !== want.table_full_drop
                || got.stat_value !== want.stat_value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    iolh_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    iolh_out_t m_data;

    latency_scoreboard board;
    int  cycles;
    bit  long_hold;
    bit  steady_recv;
    int  sent;
    logic [31:0] live_dev[$];
    logic [63:0] live_sec[$];
    logic [63:0] live_time[$];
    logic [63:0] clock_ns;

    io_latency_log2_histogram_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.note_item(s_data);
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    initial begin
        int phase;
        m_ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) m_ready <= 1'b0;
            else if (steady_recv) m_ready <= 1'b1;
            else begin
                phase = (phase + 1) % 11;
                m_ready <= (phase < 6) ? ($urandom_range(0, 3) != 0) : (phase != 8);
            end
        end
    end

    // The valid line stays high after a transfer; it is dropped only where the sender pauses.
    task automatic send_item(iolh_in_t it);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic gap();
        int n;
        if ($urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic iolh_in_t make_item(logic [1:0] md, logic [31:0] dev,
                                           logic [63:0] sec, logic [63:0] t,
                                           logic [31:0] cnt, logic [7:0] op,
                                           logic [6:0] idx);
        iolh_in_t it;
        it.mode = md;
        it.device_id = dev;
        it.sector_number = sec;
        it.time_ns = t;
        it.sector_count = cnt;
        it.op_code_char = op;
        it.stat_index = idx;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] rand_op();
        return ($urandom_range(0, 1) != 0) ? READ_CHAR : 8'($urandom());
    endfunction

    task automatic random_stat();
        send_item(make_item(MODE_READ, $urandom(), rand64(), rand64(), $urandom(),
                            8'($urandom()), 7'($urandom_range(0, 127))));
    endtask

    initial begin
        int j, burst, choice;
        logic [63:0] dt;
        board = new();
        board.rd_count = 0;
        board.wr_count = 0;
        board.rd_bytes = 0;
        board.wr_bytes = 0;
        for (int i = 0; i < BINS; i++) begin
            board.rd_bins[i] = 0;
            board.wr_bins[i] = 0;
        end
        long_hold = 1'b0;
        steady_recv = 1'b0;
        sent = 0;
        clock_ns = 64'd5000;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: extremes, zero and saturated latency, overwrite, miss, unused mode.
        send_item(make_item(MODE_COMPLETE, 32'd1, 64'd1, 64'd0, 32'd0, READ_CHAR, 7'd0));
        send_item(make_item(MODE_ISSUE, '1, '1, 64'd100, 32'd0, 8'd0, 7'h7f));
        send_item(make_item(MODE_COMPLETE, '1, '1, 64'd999, '1, READ_CHAR, 7'd0));
        send_item(make_item(MODE_ISSUE, 32'd0, 64'd0, '1, 32'd0, 8'd0, 7'd0));
        send_item(make_item(MODE_ISSUE, 32'd0, 64'd0, 64'd1000, 32'd0, 8'd0, 7'd0));
        send_item(make_item(MODE_COMPLETE, 32'd0, 64'd0, 64'd999, '1, 8'hff, 7'd0));
        send_item(make_item(MODE_ISSUE, 32'd7, 64'd9, 64'd0, 32'd0, 8'd0, 7'd0));
        send_item(make_item(MODE_COMPLETE, 32'd7, 64'd9, '1, 32'd3, 8'd0, 7'd0));
        send_item(make_item(MODE_ISSUE, 32'd7, 64'd9, 64'd10, 32'd0, 8'd0, 7'd0));
        send_item(make_item(MODE_COMPLETE, 32'd7, 64'd10, 64'd50, 32'd1, 8'd0, 7'd0));
        send_item(make_item(MODE_COMPLETE, 32'd7, 64'd9, 64'd4010, 32'd1, READ_CHAR, 7'd0));
        send_item(make_item(2'd3, '1, '1, '1, '1, '1, '1));
        for (int i = 0; i < 2 * BINS + 4; i += 7)
            send_item(make_item(MODE_READ, 32'd0, 64'd0, 64'd0, 32'd0, 8'd0, 7'(i)));
        for (int i = 2 * BINS; i < 2 * BINS + 4; i++)
            send_item(make_item(MODE_READ, 32'd0, 64'd0, 64'd0, 32'd0, 8'd0, 7'(i)));
        send_item(make_item(MODE_READ, 32'd0, 64'd0, 64'd0, 32'd0, 8'd0, 7'h7f));

        // Fill the table to overflow, with the receiver held off for a long stretch.
        long_hold = 1'b1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                long_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < DEPTH + 3; i++) begin
            live_dev.push_back(32'(i));
            live_sec.push_back(rand64());
            live_time.push_back(clock_ns);
            send_item(make_item(MODE_ISSUE, live_dev[$], live_sec[$], clock_ns,
                                $urandom(), 8'($urandom()), 7'($urandom())));
        end
        // The last three were dropped; forget them.
        repeat (3) begin
            void'(live_dev.pop_back());
            void'(live_sec.pop_back());
            void'(live_time.pop_back());
        end
        drain();

        // Random part: mostly matched issue/completion pairs with random latencies.
        while (sent < 480) begin
            burst = $urandom_range(1, 12);
            steady_recv = ($urandom_range(0, 5) == 0);
            repeat (burst) begin
                choice = $urandom_range(0, 9);
                clock_ns += $urandom_range(0, 100000);
                if (choice < 4 && live_dev.size() > 0) begin
                    j = $urandom_range(0, live_dev.size() - 1);
                    case ($urandom_range(0, 3))
                        0: dt = 64'($urandom_range(0, 2000));
                        1: dt = rand64();
                        2: dt = 64'd1 << $urandom_range(0, 63);
                        default: dt = 64'($urandom_range(0, 50000000));
                    endcase
                    send_item(make_item(MODE_COMPLETE, live_dev[j], live_sec[j],
                                        live_time[j] + dt, $urandom(), rand_op(),
                                        7'($urandom())));
                    live_dev.delete(j);
                    live_sec.delete(j);
                    live_time.delete(j);
                end else if (choice < 7 && live_dev.size() < DEPTH) begin
                    live_dev.push_back($urandom_range(0, 3) == 0 ? $urandom() : 32'd5);
                    live_sec.push_back(rand64());
                    live_time.push_back($urandom_range(0, 7) == 0 ? rand64() : clock_ns);
                    send_item(make_item(MODE_ISSUE, live_dev[$], live_sec[$], live_time[$],
                                        $urandom(), 8'($urandom()), 7'($urandom())));
                end else if (choice == 7) begin
                    send_item(make_item(MODE_COMPLETE, $urandom(), rand64(), rand64(),
                                        $urandom(), rand_op(), 7'($urandom())));
                end else begin
                    random_stat();
                end
            end
            gap();
            if ($urandom_range(0, 30) == 0) drain();
        end
        for (int i = 0; i < 2 * BINS + 4; i++)
            send_item(make_item(MODE_READ, 32'd0, 64'd0, 64'd0, 32'd0, 8'd0, 7'(i)));

        fork
            begin
                drain();
                repeat (600) @(posedge aclk);
            end
            begin
                repeat (200000) @(posedge aclk);
            end
        join_any
        $display("Sent %0d items, checked %0d results: %0d hits, %0d table-full drops.",
                 sent, board.checked, board.hits, board.drops);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results outstanding", board.mismatches,
                     board.pending.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
